// ===== hdl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Comment/code separator package
// Shared scanner states, character codes and the result entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  typedef enum logic [2:0] {
    ST_CODE  = 3'd0,
    ST_STR   = 3'd1,
    ST_SLASH = 3'd2,
    ST_BLOCK = 3'd3,
    ST_STAR  = 3'd4,
    ST_LINE  = 3'd5
  } scan_state_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] b;
    logic       code;
    logic       note;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/comment_code_separator_core.sv =====
// ----------------------------------------------------------------------------
// Comment/code separator core
// Steers each source byte to the code stream, the comment stream or both.
// ----------------------------------------------------------------------------
// The first result of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one result and the output is not stalled.
// A byte that yields n results (up to three) occupies the result buffer until
// they drain, and the input is stalled until its final result is taken.
// Reset returns the scanner to the code state and empties the result buffer.
`default_nettype none

module comment_code_separator_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            to_code,
  output logic            to_note,
  output logic            last_of_run
);

  ccs_pkg::scan_state_t scan_state;
  ccs_pkg::scan_state_t scan_state_next;
  ccs_pkg::result_t     buf_item [ccs_pkg::MaxResults];
  ccs_pkg::result_t     item_next [ccs_pkg::MaxResults];
  logic [1:0]           rem;
  logic [1:0]           idx;
  logic [1:0]           cnt_next;
  logic                 in_take;
  logic                 out_take;

  assign out_valid   = (rem != 2'd0);
  assign out_take    = out_valid && !out_stall;
  assign in_stall    = !((rem == 2'd0) || ((rem == 2'd1) && !out_stall));
  assign in_take     = in_valid && !in_stall;
  assign out_byte    = buf_item[idx].b;
  assign to_code     = buf_item[idx].code;
  assign to_note     = buf_item[idx].note;
  assign last_of_run = (rem == 2'd1);

  always_comb begin
    scan_state_next = scan_state;
    cnt_next        = 2'd0;
    item_next[0]    = '{b: ch, code: 1'b1, note: 1'b0};
    item_next[1]    = '{b: ch, code: 1'b1, note: 1'b0};
    item_next[2]    = '{b: ccs_pkg::CH_NL, code: 1'b0, note: 1'b1};
    unique case (scan_state)
      ccs_pkg::ST_STR: begin
        if (ch == ccs_pkg::CH_QUOTE) begin
          scan_state_next = ccs_pkg::ST_CODE;
        end
        cnt_next = 2'd1;
      end
      ccs_pkg::ST_SLASH: begin
        cnt_next = 2'd2;
        if ((ch == ccs_pkg::CH_SLASH) || (ch == ccs_pkg::CH_STAR)) begin
          scan_state_next = (ch == ccs_pkg::CH_SLASH) ? ccs_pkg::ST_LINE
                                                      : ccs_pkg::ST_BLOCK;
          item_next[0] = '{b: ccs_pkg::CH_SLASH, code: 1'b0, note: 1'b1};
          item_next[1] = '{b: ch, code: 1'b0, note: 1'b1};
        end else begin
          scan_state_next = ccs_pkg::ST_CODE;
          item_next[0] = '{b: ccs_pkg::CH_SLASH, code: 1'b1, note: 1'b0};
        end
      end
      ccs_pkg::ST_BLOCK: begin
        item_next[0] = '{b: ch, code: 1'b0, note: 1'b1};
        if (ch == ccs_pkg::CH_STAR) begin
          scan_state_next = ccs_pkg::ST_STAR;
        end else begin
          cnt_next = 2'd1;
        end
      end
      ccs_pkg::ST_STAR: begin
        item_next[0] = '{b: ccs_pkg::CH_STAR, code: 1'b0, note: 1'b1};
        item_next[1] = '{b: ch, code: 1'b0, note: 1'b1};
        if (ch == ccs_pkg::CH_SLASH) begin
          scan_state_next = ccs_pkg::ST_CODE;
          cnt_next = 2'd3;
        end else begin
          scan_state_next = ccs_pkg::ST_BLOCK;
          cnt_next = 2'd2;
        end
      end
      ccs_pkg::ST_LINE: begin
        cnt_next = 2'd1;
        if (ch == ccs_pkg::CH_NL) begin
          scan_state_next = ccs_pkg::ST_CODE;
          item_next[0] = '{b: ch, code: 1'b1, note: 1'b1};
        end else begin
          item_next[0] = '{b: ch, code: 1'b0, note: 1'b1};
        end
      end
      default: begin
        if (ch == ccs_pkg::CH_SLASH) begin
          scan_state_next = ccs_pkg::ST_SLASH;
        end else begin
          if (ch == ccs_pkg::CH_QUOTE) begin
            scan_state_next = ccs_pkg::ST_STR;
          end
          cnt_next = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= ccs_pkg::ST_CODE;
      rem        <= 2'd0;
      idx        <= 2'd0;
    end else if (in_take) begin
      scan_state <= scan_state_next;
      rem        <= cnt_next;
      idx        <= 2'd0;
    end else if (out_take) begin
      rem <= rem - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_item <= item_next;
    end
  end

  // While results remain, a new item is only taken as the buffer drains its final result.
  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    (in_take && out_valid) |-> (last_of_run && out_take))
    else $error("item taken while earlier results remain");

  // The buffered burst never exceeds three results.
  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, idx} + {1'b0, rem}) <= 3'd3))
    else $error("result buffer index out of range");

  // Every result goes to at least one stream.
  a_has_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (to_code || to_note))
    else $error("result with no stream");

  // Closing a block comment yields star, slash and newline.
  a_close_burst: assert property (@(posedge clk) disable iff (rst)
    (in_take && (scan_state == ccs_pkg::ST_STAR) && (ch == ccs_pkg::CH_SLASH))
    |=> ((rem == 2'd3) && (out_byte == ccs_pkg::CH_STAR)
         && (scan_state == ccs_pkg::ST_CODE)))
    else $error("block comment close burst malformed");

endmodule

`default_nettype wire

// ===== bench/tb_comment_code_separator_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the comment/code separator core
// Feeds source text one byte per item and checks every emitted byte, its
// stream flags and the last-of-run marker against a scanner model kept here,
// under random idling on both sides and long output hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_comment_code_separator_core;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 100;

  typedef struct {
    logic [7:0] b;
    logic       code;
    logic       note;
    logic       last;
  } emit_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       to_code;
  logic       to_note;
  logic       last_of_run;

  ccs_pkg::scan_state_t scan_st = ccs_pkg::ST_CODE;
  emit_t       emit_q[$];
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  bit          tx_idling = 1'b1;
  logic        rx_idling = 1'b1;
  logic        long_hold_req = 1'b0;

  comment_code_separator_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ch(ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .to_code(to_code),
    .to_note(to_note),
    .last_of_run(last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL comment_code_separator_core");
      $finish;
    end
  end

  function automatic void push_emit(logic [7:0] b, logic code, logic note, logic last);
    emit_t e;
    e.b = b;
    e.code = code;
    e.note = note;
    e.last = last;
    emit_q.push_back(e);
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    case (scan_st)
      ccs_pkg::ST_CODE: begin
        if (c == ccs_pkg::CH_SLASH) begin
          scan_st = ccs_pkg::ST_SLASH;
        end else begin
          if (c == ccs_pkg::CH_QUOTE) scan_st = ccs_pkg::ST_STR;
          push_emit(c, 1'b1, 1'b0, 1'b1);
        end
      end
      ccs_pkg::ST_STR: begin
        if (c == ccs_pkg::CH_QUOTE) scan_st = ccs_pkg::ST_CODE;
        push_emit(c, 1'b1, 1'b0, 1'b1);
      end
      ccs_pkg::ST_SLASH: begin
        if (c == ccs_pkg::CH_SLASH || c == ccs_pkg::CH_STAR) begin
          if (c == ccs_pkg::CH_SLASH) scan_st = ccs_pkg::ST_LINE;
          else scan_st = ccs_pkg::ST_BLOCK;
          push_emit(ccs_pkg::CH_SLASH, 1'b0, 1'b1, 1'b0);
          push_emit(c, 1'b0, 1'b1, 1'b1);
        end else begin
          scan_st = ccs_pkg::ST_CODE;
          push_emit(ccs_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0);
          push_emit(c, 1'b1, 1'b0, 1'b1);
        end
      end
      ccs_pkg::ST_BLOCK: begin
        if (c == ccs_pkg::CH_STAR) scan_st = ccs_pkg::ST_STAR;
        else push_emit(c, 1'b0, 1'b1, 1'b1);
      end
      ccs_pkg::ST_STAR: begin
        if (c == ccs_pkg::CH_SLASH) begin
          scan_st = ccs_pkg::ST_CODE;
          push_emit(ccs_pkg::CH_STAR, 1'b0, 1'b1, 1'b0);
          push_emit(ccs_pkg::CH_SLASH, 1'b0, 1'b1, 1'b0);
          push_emit(ccs_pkg::CH_NL, 1'b0, 1'b1, 1'b1);
        end else begin
          scan_st = ccs_pkg::ST_BLOCK;
          push_emit(ccs_pkg::CH_STAR, 1'b0, 1'b1, 1'b0);
          push_emit(c, 1'b0, 1'b1, 1'b1);
        end
      end
      default: begin
        if (c == ccs_pkg::CH_NL) begin
          scan_st = ccs_pkg::ST_CODE;
          push_emit(c, 1'b1, 1'b1, 1'b1);
        end else begin
          push_emit(c, 1'b0, 1'b1, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    emit_t e;
    if (!rst && out_valid && !out_stall) begin
      if (emit_q.size() == 0) begin
        $error("out_byte: no result expected, actual %02h", out_byte);
        fail_count++;
      end else begin
        e = emit_q.pop_front();
        if (out_byte !== e.b) begin
          $error("out_byte: expected %02h, actual %02h", e.b, out_byte);
          fail_count++;
        end
        if (to_code !== e.code) begin
          $error("to_code: expected %0b, actual %0b", e.code, to_code);
          fail_count++;
        end
        if (to_note !== e.note) begin
          $error("to_note: expected %0b, actual %0b", e.note, to_note);
          fail_count++;
        end
        if (last_of_run !== e.last) begin
          $error("last_of_run: expected %0b, actual %0b", e.last, last_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= b;
    do @(posedge clk); while (in_stall);
    scan_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return ccs_pkg::CH_STAR;
      1: return ccs_pkg::CH_SLASH;
      2: return ccs_pkg::CH_QUOTE;
      3: return ccs_pkg::CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_fragment();
    int len;
    len = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0, 1: repeat (len + 1) send_byte(8'($urandom_range(0, 255)));
      2: begin
        send_byte(ccs_pkg::CH_QUOTE);
        repeat (len) send_byte(pick_byte());
        send_byte(ccs_pkg::CH_QUOTE);
      end
      3, 4: begin
        send_byte(ccs_pkg::CH_SLASH);
        send_byte(ccs_pkg::CH_SLASH);
        repeat (len) send_byte(pick_byte());
        send_byte(ccs_pkg::CH_NL);
      end
      5, 6: begin
        send_byte(ccs_pkg::CH_SLASH);
        send_byte(ccs_pkg::CH_STAR);
        repeat (len) send_byte(pick_byte());
        send_byte(ccs_pkg::CH_STAR);
        send_byte(ccs_pkg::CH_SLASH);
      end
      7: begin
        send_byte(ccs_pkg::CH_SLASH);
        send_byte(pick_byte());
      end
      8: repeat (len + 1) send_byte(8'($urandom_range(8'h61, 8'h7A)));
      default: begin
        repeat (len + 1) begin
          if ($urandom_range(0, 1) == 0) send_byte(ccs_pkg::CH_STAR);
          else send_byte(ccs_pkg::CH_SLASH);
        end
      end
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (emit_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] text[$];
    text = '{8'h00, 8'hFF, ccs_pkg::CH_QUOTE, ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR,
             ccs_pkg::CH_QUOTE, ccs_pkg::CH_SLASH, 8'h78, ccs_pkg::CH_SLASH,
             ccs_pkg::CH_QUOTE, ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, 8'hFF,
             ccs_pkg::CH_NL, ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, 8'h00,
             ccs_pkg::CH_STAR, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR,
             ccs_pkg::CH_SLASH, 8'h61, ccs_pkg::CH_NL};
    foreach (text[i]) send_byte(text[i]);
  endtask

  task automatic test_random_text(int unsigned n_bytes);
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 11) == 0) tx_idling = !tx_idling;
      if ($urandom_range(0, 11) == 0) rx_idling <= !rx_idling;
      send_fragment();
    end
  endtask

  task automatic test_output_hold();
    tx_idling = 1'b0;
    long_hold_req <= 1'b1;
    send_byte(ccs_pkg::CH_SLASH);
    send_byte(ccs_pkg::CH_STAR);
    repeat (40) send_byte(pick_byte());
    send_byte(ccs_pkg::CH_STAR);
    send_byte(ccs_pkg::CH_SLASH);
    wait_drained();
    tx_idling = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (4) send_fragment();
    wait_drained();
    repeat (4) send_fragment();
  endtask

  task automatic test_no_idling();
    tx_idling = 1'b0;
    rx_idling <= 1'b0;
    repeat (10) send_fragment();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_hold();
    test_random_text(64);
    test_pause_until_drained();
    test_no_idling();
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS comment_code_separator_core");
    end else begin
      $display("FAIL comment_code_separator_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/ccs_pkg.sv
hdl/comment_code_separator_core.sv
bench/tb_comment_code_separator_core.sv
